>>> rtl/snpdf_pkg.sv
// snpdf_pkg: constants, types and handshake structs of the packet deframer
// used by every module of the deframer but snpdf_ram; depends on nothing else
package snpdf_pkg;

  localparam int MAX_WORDS   = 16;
  localparam int STORE_BYTES = MAX_WORDS * 4;
  localparam int WADDR_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WCNT_W      = $clog2(MAX_WORDS + 1);

  localparam logic [7:0]  HDR_S      = 8'h73;
  localparam logic [7:0]  HDR_N      = 8'h6e;
  localparam logic [7:0]  HDR_P      = 8'h70;
  localparam logic [15:0] HDR_SUM    = 16'(HDR_S) + 16'(HDR_N) + 16'(HDR_P);
  localparam logic [7:0]  LEN_MAX    = 8'd255;
  localparam logic [7:0]  LEN_MIN    = 8'd7;
  localparam logic [7:0]  DELAY_LEN  = 8'd5;
  localparam logic [7:0]  BODY_SKIP  = 8'd2;

  localparam logic [1:0] HP_NONE = 2'd0;
  localparam logic [1:0] HP_S    = 2'd1;
  localparam logic [1:0] HP_SN   = 2'd2;

  localparam logic [1:0] FS_OK       = 2'd0;
  localparam logic [1:0] FS_SHORT    = 2'd1;
  localparam logic [1:0] FS_MISMATCH = 2'd2;
  localparam logic [1:0] FS_LONG     = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic byte_take;
    logic read_first;
    logic read_next;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr_hit;
    logic last;
  } dp_stat_t;

endpackage

>>> rtl/snpdf_ram.sv
// snpdf_ram: generic simple dual-port ram, one write and one registered read port
// no package dependency
module snpdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/snpdf_dp.sv
// snpdf_dp: datapath of the deframer - header match, delay line, sum, payload lanes
// depends on snpdf_pkg and snpdf_ram
module snpdf_dp
  import snpdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  dp_cmd_t      cmd,
  output dp_stat_t     stat,
  input  logic [7:0]   rx_byte,
  output logic [1:0]   frame_status,
  output logic [7:0]   packet_type,
  output logic [7:0]   reg_address,
  output logic [3:0]   word_index,
  output logic [31:0]  data_word,
  output logic         word_valid,
  output logic         last_word
);

  logic [1:0]  hdr_prog;
  logic [7:0]  frame_len;
  logic [15:0] run_sum;
  logic [7:0]  tail [5];
  logic [7:0]  type_hold;
  logic [7:0]  addr_hold;
  logic        ovf;

  logic [1:0]        res_status;
  logic [7:0]        res_type;
  logic [7:0]        res_addr;
  logic [WCNT_W-1:0] res_words;
  logic [7:0]        res_plen;
  logic              res_single;
  logic [WADDR_W-1:0] w;

  logic [7:0]  old_byte;
  logic        in_body;
  logic [7:0]  pos;
  logic [7:0]  body;
  logic        store_we;
  logic [7:0]  len_next;
  logic [15:0] sum_next;
  logic [7:0]  type_next;
  logic [7:0]  addr_next;
  logic        ovf_next;
  logic        hdr_hit;
  logic [15:0] calc;
  logic [15:0] told;
  logic [7:0]  plen;
  logic [8:0]  words_wide;
  logic [1:0]  status_next;
  logic [WADDR_W-1:0] raddr;
  logic        re;
  logic [7:0]  rd [4];

  always_comb begin
    old_byte  = tail[4];
    in_body   = frame_len >= DELAY_LEN;
    pos       = frame_len - DELAY_LEN;
    body      = pos - BODY_SKIP;
    store_we  = cmd.byte_take && in_body && (pos >= BODY_SKIP)
                && (9'(body) < 9'(STORE_BYTES));
    sum_next  = run_sum + (in_body ? 16'(old_byte) : 16'd0);
    type_next = (in_body && pos == 8'd0) ? old_byte : type_hold;
    addr_next = (in_body && pos == 8'd1) ? old_byte : addr_hold;
    ovf_next  = ovf || (frame_len == LEN_MAX)
                || (in_body && (pos >= BODY_SKIP) && (9'(body) >= 9'(STORE_BYTES)));
    len_next  = (frame_len == LEN_MAX) ? LEN_MAX : frame_len + 8'd1;
    hdr_hit   = (rx_byte == HDR_P) && (hdr_prog == HP_SN);
    calc      = sum_next + HDR_SUM;
    told      = {tail[3], tail[2]};
    plen      = len_next - LEN_MIN;
    words_wide = (9'(plen) + 9'd3) >> 2;
    priority if (len_next < LEN_MIN) begin
      status_next = FS_SHORT;
    end else if (ovf_next) begin
      status_next = FS_LONG;
    end else if (calc != told) begin
      status_next = FS_MISMATCH;
    end else begin
      status_next = FS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_prog  <= HP_NONE;
      frame_len <= '0;
      run_sum   <= '0;
      type_hold <= '0;
      addr_hold <= '0;
      ovf       <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        tail[i] <= '0;
      end
    end else if (cmd.byte_take) begin
      if (hdr_hit) begin
        hdr_prog  <= HP_NONE;
        frame_len <= '0;
        run_sum   <= '0;
        type_hold <= '0;
        addr_hold <= '0;
        ovf       <= 1'b0;
        for (int i = 0; i < 5; i++) begin
          tail[i] <= '0;
        end
      end else begin
        frame_len <= len_next;
        run_sum   <= sum_next;
        type_hold <= type_next;
        addr_hold <= addr_next;
        ovf       <= ovf_next;
        tail[0]   <= rx_byte;
        for (int i = 1; i < 5; i++) begin
          tail[i] <= tail[i-1];
        end
        priority if (rx_byte == HDR_S) begin
          hdr_prog <= HP_S;
        end else if (rx_byte == HDR_N && hdr_prog == HP_S) begin
          hdr_prog <= HP_SN;
        end else begin
          hdr_prog <= HP_NONE;
        end
      end
    end
  end

  // frame verdict, held while the words drain
  always_ff @(posedge clk) begin
    if (cmd.byte_take && hdr_hit) begin
      res_status <= status_next;
      res_type   <= (status_next == FS_SHORT) ? 8'd0 : type_next;
      res_addr   <= (status_next == FS_SHORT) ? 8'd0 : addr_next;
      res_words  <= WCNT_W'(words_wide);
      res_plen   <= plen;
      res_single <= (status_next != FS_OK) || (words_wide == 9'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_first) begin
      w <= '0;
    end else if (cmd.read_next) begin
      w <= w + WADDR_W'(1);
    end
  end

  assign re    = cmd.read_first || cmd.read_next;
  assign raddr = cmd.read_first ? '0 : w + WADDR_W'(1);

  for (genvar j = 0; j < 4; j++) begin : g_lane
    snpdf_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WORDS)
    ) u_lane (
      .clk   (clk),
      .we    (store_we && (body[1:0] == 2'(j))),
      .waddr (WADDR_W'(body >> 2)),
      .wdata (old_byte),
      .re    (re),
      .raddr (raddr),
      .rdata (rd[j])
    );
  end

  always_comb begin
    data_word = '0;
    for (int j = 0; j < 4; j++) begin
      if (!res_single && (9'({w, 2'(j)}) < 9'(res_plen))) begin
        data_word[31-8*j -: 8] = rd[j];
      end
    end
  end

  assign stat.hdr_hit = hdr_hit;
  assign stat.last    = res_single || ((WCNT_W'(w) + WCNT_W'(1)) == res_words);

  assign frame_status = res_status;
  assign packet_type  = res_type;
  assign reg_address  = res_addr;
  assign word_index   = res_single ? 4'd0 : 4'(w);
  assign word_valid   = !res_single;
  assign last_word    = stat.last;

endmodule

>>> rtl/snpdf_ctrl.sv
// snpdf_ctrl: controller state machine sequencing byte intake and word drain
// depends on snpdf_pkg
module snpdf_ctrl
  import snpdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_stall,
  output logic     result_valid,
  input  logic     result_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    byte_stall     = 1'b1;
    result_valid   = 1'b0;
    unique case (state)
      S_IDLE: begin
        byte_stall    = 1'b0;
        cmd.byte_take = byte_valid;
        if (byte_valid && stat.hdr_hit) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.read_first = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        result_valid = 1'b1;
        if (!result_stall) begin
          if (stat.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.read_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/snp_packet_deframer_checksum.sv
// snp_packet_deframer_checksum: top level of the serial packet deframer
// depends on snpdf_pkg, snpdf_ctrl, snpdf_dp (and snpdf_ram through it)
//
// usage
//   byte channel: rx_byte with byte_valid / byte_stall, one received byte per
//   transfer. result channel: frame_status, packet_type, reg_address,
//   word_index, data_word, word_valid, last_word with result_valid /
//   result_stall.
//   a frame ends when the bytes 's','n','p' arrive back to back; the block
//   then emits each payload word (big-endian, last_word on the final one),
//   or a single result for an error or an empty payload.
//   a byte that does not complete a header leaves byte_stall low. after the
//   closing 'p' byte_stall is high while the S_LOAD state reads the payload
//   lanes and then while the results drain, one result per cycle while
//   result_stall is low. the first result appears in S_EMIT, after S_LOAD.
//   S_LOAD is needed for the registered read of the four payload lane rams.
//   while result_stall is high the result fields hold and no byte is taken.
//   rst (synchronous) clears the header match, length, sum, delay line and
//   held bytes; the payload rams need no clearing.
module snp_packet_deframer_checksum
  import snpdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  logic        byte_valid,
  output logic        byte_stall,
  output logic [1:0]  frame_status,
  output logic [7:0]  packet_type,
  output logic [7:0]  reg_address,
  output logic [3:0]  word_index,
  output logic [31:0] data_word,
  output logic        word_valid,
  output logic        last_word,
  output logic        result_valid,
  input  logic        result_stall
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  snpdf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  snpdf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .rx_byte      (rx_byte),
    .frame_status (frame_status),
    .packet_type  (packet_type),
    .reg_address  (reg_address),
    .word_index   (word_index),
    .data_word    (data_word),
    .word_valid   (word_valid),
    .last_word    (last_word)
  );

  a_no_intake_while_draining: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> byte_stall)
    else $error("byte intake open while results drain");

  a_header_stalls_intake: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !byte_stall && stat.hdr_hit) |=> (byte_stall && !result_valid))
    else $error("closing header did not start the lane read");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && last_word) |=> (!result_valid && !byte_stall))
    else $error("results continue after the last word");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !word_valid) |-> (last_word && data_word == 32'd0))
    else $error("error or empty result not marked last");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for snp_packet_deframer_checksum, byte stream in, words out
// depends on snpdf_pkg and the deframer rtl; predicts each frame's results and checks them
module tb;
  import snpdf_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int DRAIN_MARK   = -1;
  localparam int STREAM_BYTES = 450;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  ptype;
    logic [7:0]  addr;
    logic [3:0]  idx;
    logic [31:0] word;
    logic        valid;
    logic        last;
  } frame_res_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic [7:0]  rx_byte      = 8'h00;
  logic        byte_valid   = 1'b0;
  logic        byte_stall;
  logic [1:0]  frame_status;
  logic [7:0]  packet_type;
  logic [7:0]  reg_address;
  logic [3:0]  word_index;
  logic [31:0] data_word;
  logic        word_valid;
  logic        last_word;
  logic        result_valid;
  logic        result_stall = 1'b0;

  int          rx_stream[$];
  frame_res_t  pending_words[$];
  frame_res_t  head_res;
  int          fail_cnt   = 0;
  int          cycle_cnt  = 0;
  bit          byte_taken = 1'b0;
  int          burst_left = 1;
  int          gap_left   = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_run  = 0;

  // deframer state as seen from the byte stream
  logic [1:0]  hdr_prog  = HP_NONE;
  int          frm_len   = 0;
  logic [15:0] run_sum   = '0;
  logic [39:0] tail      = '0;
  logic [7:0]  type_hold = '0;
  logic [7:0]  addr_hold = '0;
  logic [7:0]  pstore [STORE_BYTES];
  bit          ovf       = 1'b0;

  snp_packet_deframer_checksum u_dut (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .frame_status (frame_status),
    .packet_type  (packet_type),
    .reg_address  (reg_address),
    .word_index   (word_index),
    .data_word    (data_word),
    .word_valid   (word_valid),
    .last_word    (last_word),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void deframe_byte(input logic [7:0] b);
    int          pos;
    int          plen;
    int          nwords;
    int          w;
    int          j;
    int          p;
    logic [7:0]  tail_out;
    logic [15:0] calc;
    logic [15:0] told;
    logic [31:0] word;
    // oldest byte of the delay line joins the frame body
    if (frm_len >= 5) begin
      pos      = frm_len - 5;
      tail_out = tail[39:32];
      run_sum  = run_sum + 16'(tail_out);
      if (pos == 0) type_hold = tail_out;
      else if (pos == 1) addr_hold = tail_out;
      else if (pos - 2 < STORE_BYTES) pstore[pos - 2] = tail_out;
      else ovf = 1'b1;
    end
    tail = {tail[31:0], b};
    if (frm_len >= 255) ovf = 1'b1;
    else frm_len++;

    if (b == HDR_S) begin
      hdr_prog = HP_S;
      return;
    end
    if (b == HDR_N && hdr_prog == HP_S) begin
      hdr_prog = HP_SN;
      return;
    end
    if (!(b == HDR_P && hdr_prog == HP_SN)) begin
      hdr_prog = HP_NONE;
      return;
    end

    calc = run_sum + HDR_SUM;
    told = tail[39:24];
    if (frm_len < 7) begin
      pending_words.push_back(frame_res_t'{FS_SHORT, 8'h00, 8'h00, 4'd0, 32'd0, 1'b0, 1'b1});
    end else if (ovf) begin
      pending_words.push_back(frame_res_t'{FS_LONG, type_hold, addr_hold, 4'd0, 32'd0, 1'b0,
                                           1'b1});
    end else if (calc != told) begin
      pending_words.push_back(frame_res_t'{FS_MISMATCH, type_hold, addr_hold, 4'd0, 32'd0,
                                           1'b0, 1'b1});
    end else begin
      plen   = frm_len - 7;
      nwords = (plen + 3) / 4;
      if (nwords == 0) begin
        pending_words.push_back(frame_res_t'{FS_OK, type_hold, addr_hold, 4'd0, 32'd0, 1'b0,
                                             1'b1});
      end
      for (w = 0; w < nwords; w++) begin
        word = '0;
        for (j = 0; j < 4; j++) begin
          p    = w * 4 + j;
          word = {word[23:0], (p < plen && p < STORE_BYTES) ? pstore[p] : 8'h00};
        end
        pending_words.push_back(frame_res_t'{FS_OK, type_hold, addr_hold, 4'(w), word, 1'b1,
                                             1'(w + 1 == nwords)});
      end
    end
    hdr_prog  = HP_NONE;
    frm_len   = 0;
    run_sum   = '0;
    tail      = '0;
    type_hold = '0;
    addr_hold = '0;
    ovf       = 1'b0;
  endfunction

  // random byte, biased towards header characters
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return HDR_S;
      1:       return HDR_N;
      2:       return HDR_P;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_frame(input logic [7:0] ptype, input logic [7:0] addr,
                                     input int plen, input bit bad_sum, input int fill);
    logic [15:0] sum;
    logic [7:0]  b;
    int          i;
    sum = HDR_SUM + 16'(ptype) + 16'(addr);
    rx_stream.push_back(int'(ptype));
    rx_stream.push_back(int'(addr));
    for (i = 0; i < plen; i++) begin
      b = (fill < 0) ? pick_byte() : 8'(fill);
      sum += 16'(b);
      rx_stream.push_back(int'(b));
    end
    if (bad_sum) sum ^= 16'($urandom_range(1, 16'hffff));
    rx_stream.push_back(int'(sum[15:8]));
    rx_stream.push_back(int'(sum[7:0]));
    rx_stream.push_back(int'(HDR_S));
    rx_stream.push_back(int'(HDR_N));
    rx_stream.push_back(int'(HDR_P));
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // byte driver: bursts with random gaps, holds until transfer
  always @(negedge clk) begin
    if (!rst && (!byte_valid || byte_taken)) begin
      byte_taken = 1'b0;
      if (rx_stream.size() > 0 && rx_stream[0] == DRAIN_MARK && pending_words.size() == 0)
        void'(rx_stream.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        byte_valid <= 1'b0;
      end else if (rx_stream.size() > 0 && rx_stream[0] != DRAIN_MARK) begin
        rx_byte    <= 8'(rx_stream.pop_front());
        byte_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run  = $urandom_range(20, 150);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      default:     result_stall <= (cycle_cnt % 7 < 3);
    endcase
  end

  // monitor: predict on byte transfer, check on result transfer
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (!rst) begin
      if (byte_valid && !byte_stall) begin
        deframe_byte(rx_byte);
        byte_taken = 1'b1;
      end
      if (result_valid && !result_stall) begin
        if (pending_words.size() == 0) begin
          $error("result with nothing pending: status %0d word %h", frame_status, data_word);
          fail_cnt++;
        end else begin
          head_res = pending_words.pop_front();
          check_field("frame_status", 32'(head_res.status), 32'(frame_status));
          check_field("packet_type", 32'(head_res.ptype), 32'(packet_type));
          check_field("reg_address", 32'(head_res.addr), 32'(reg_address));
          check_field("word_index", 32'(head_res.idx), 32'(word_index));
          check_field("data_word", head_res.word, data_word);
          check_field("word_valid", 32'(head_res.valid), 32'(word_valid));
          check_field("last_word", 32'(head_res.last), 32'(last_word));
        end
      end
    end
  end

  initial begin
    int  kind;
    int  n;
    int  plen;
    bit  sat_done;
    sat_done = 1'b0;
    foreach (pstore[k]) pstore[k] = 8'h00;

    // header straight after reset, then empty, partial-word and bad-sum frames
    rx_stream.push_back(int'(HDR_S));
    rx_stream.push_back(int'(HDR_N));
    rx_stream.push_back(int'(HDR_P));
    push_frame(8'hff, 8'h00, 0, 1'b0, -1);
    push_frame(8'h00, 8'hff, 1, 1'b0, 8'hff);
    push_frame(8'h5a, 8'ha5, 0, 1'b1, -1);
    // broken header restarted by a second 's'
    rx_stream.push_back(int'(HDR_S));
    rx_stream.push_back(int'(HDR_N));
    rx_stream.push_back(int'(HDR_S));
    rx_stream.push_back(int'(HDR_N));
    rx_stream.push_back(int'(HDR_P));
    rx_stream.push_back(DRAIN_MARK);

    while (rx_stream.size() < STREAM_BYTES) begin
      if (!sat_done && rx_stream.size() > 200) begin
        // frame length saturates
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 250, 1'b0, -1);
        sat_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        n = $urandom_range(0, 19);
        plen = (n < 15) ? $urandom_range(0, 12) : (n < 19) ? $urandom_range(13, 63) : STORE_BYTES;
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), plen, 1'b0, -1);
      end else if (kind < 72) begin
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 20), 1'b1, -1);
      end else if (kind < 78) begin
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   $urandom_range(STORE_BYTES + 1, STORE_BYTES + 8), 1'b0, -1);
      end else if (kind < 86) begin
        n = $urandom_range(0, 3);
        repeat (n) rx_stream.push_back(int'($urandom_range(0, 255)));
        rx_stream.push_back(int'(HDR_S));
        rx_stream.push_back(int'(HDR_N));
        rx_stream.push_back(int'(HDR_P));
      end else if (kind < 94) begin
        n = $urandom_range(1, 6);
        repeat (n) rx_stream.push_back(int'(pick_byte()));
      end else begin
        rx_stream.push_back(DRAIN_MARK);
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 16), 1'b0, -1);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (rx_stream.size() == 0 && !byte_valid);
    wait (pending_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
